>>> hw/rtl/mpcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcc_pkg: shared types and constants of the mixer panel channel controller
// Beat layouts, register map, opcodes, report kinds and the control bundles
// that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mpcc_pkg;

    // default channel count
    localparam int CHANNELS_DEF = 6;
    // channels that have a slot in the led code word
    localparam int LED_CHANNELS = 6;

    // register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_STANDBY_DELAY = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_KNOB_DEADBAND = 1'd1;
    localparam logic [15:0] STANDBY_DELAY_RST = 16'd7000;
    localparam logic [7:0] KNOB_DEADBAND_RST = 8'd1;

    // opcodes
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_KNOB = 3'd1;
    localparam logic [2:0] OP_BUTTON = 3'd2;
    localparam logic [2:0] OP_ACTIVE = 3'd3;
    localparam logic [2:0] OP_MUTE = 3'd4;
    localparam logic [2:0] OP_VOL_REQ = 3'd5;
    localparam logic [2:0] OP_HOST = 3'd6;

    // report kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_VOLUME = 2'd1;
    localparam logic [1:0] KIND_MUTE = 2'd2;
    localparam logic [1:0] KIND_LIST = 2'd3;

    // led codes
    localparam logic [1:0] LED_OFF = 2'd0;
    localparam logic [1:0] LED_BLUE = 2'd1;
    localparam logic [1:0] LED_RED = 2'd2;
    localparam logic [1:0] LED_GREEN = 2'd3;

    // volume scaling: (raw*100+127)/255
    localparam logic [7:0] VOL_SCALE = 8'd100;
    localparam logic [6:0] VOL_ROUND = 7'd127;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] chan;
        logic [9:0] sample;
        logic       level;
        logic [5:0] mask;
        logic [7:0] elapsed_ms;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  chan_out;
        logic [6:0]  value;
        logic        last;
        logic        standby;
        logic [7:0]  hue;
        logic [11:0] led_codes;
    } out_t;

    typedef struct packed {
        logic [15:0] standby_delay_ms;
        logic [7:0]  knob_deadband;
    } cfg_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic knob_vol;
        logic restart;
        logic emit;
        logic list_emit;
    } cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic [2:0] opcode;
        logic       chan_ok;
        logic       knob_move;
        logic       press;
        logic       release_evt;
        logic       active_hit;
        logic       vol_change;
        logic       host_seen;
        logic       list_last;
        logic       out_free;
    } sts_t;

endpackage

>>> hw/rtl/mpcc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcc_regs: configuration register file
// APB-style slave holding the standby delay and the knob deadband.
// ----------------------------------------------------------------------------
module mpcc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpcc_pkg::PADDR_W-1:0] paddr,
    input  logic [mpcc_pkg::PDATA_W-1:0] pwdata,
    output logic [mpcc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output mpcc_pkg::cfg_t               cfg
);

    mpcc_pkg::cfg_t cfg_reg;
    mpcc_pkg::cfg_t cfg_next;
    logic [mpcc_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready = 1'b1;
    assign reg_idx = paddr[mpcc_pkg::PADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mpcc_pkg::REG_STANDBY_DELAY: cfg_next.standby_delay_ms = pwdata[15:0];
                mpcc_pkg::REG_KNOB_DEADBAND: cfg_next.knob_deadband = pwdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            mpcc_pkg::REG_STANDBY_DELAY: prdata = 32'(cfg_reg.standby_delay_ms);
            mpcc_pkg::REG_KNOB_DEADBAND: prdata = 32'(cfg_reg.knob_deadband);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standby_delay_ms <= mpcc_pkg::STANDBY_DELAY_RST;
            cfg_reg.knob_deadband <= mpcc_pkg::KNOB_DEADBAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/mpcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcc_ctrl: event sequencer
// Steps each accepted beat through execute, then as needed volume scaling,
// standby restart and report, or the list walk, one entry per cycle while out_free.
// ----------------------------------------------------------------------------
module mpcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mpcc_pkg::sts_t   sts,
    output mpcc_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_KVOL,
        S_RESTART,
        S_EMIT,
        S_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic emit_after_reg;
    logic emit_after_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        emit_after_next = emit_after_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                emit_after_next = 1'b0;
                case (sts.opcode)
                    mpcc_pkg::OP_TICK: state_next = S_EMIT;
                    mpcc_pkg::OP_KNOB:
                    begin
                        state_next = (sts.chan_ok && sts.knob_move) ? S_KVOL : S_IDLE;
                    end
                    mpcc_pkg::OP_BUTTON:
                    begin
                        if (sts.chan_ok && sts.press)
                        begin
                            state_next = S_RESTART;
                            emit_after_next = sts.active_hit;
                        end
                        else if (sts.chan_ok && sts.release_evt)
                        begin
                            state_next = S_RESTART;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    mpcc_pkg::OP_ACTIVE, mpcc_pkg::OP_MUTE: state_next = S_RESTART;
                    mpcc_pkg::OP_VOL_REQ: state_next = S_LIST;
                    default: state_next = S_IDLE;
                endcase
            end
            S_KVOL:
            begin
                if (sts.vol_change && sts.host_seen)
                begin
                    state_next = S_RESTART;
                    emit_after_next = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESTART:
            begin
                state_next = emit_after_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (sts.out_free && sts.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_after_reg <= emit_after_next;
        end
    end

    // commands
    assign item_ready = (state_reg == S_IDLE);
    assign cmd.load_in = (state_reg == S_IDLE) && item_valid;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.knob_vol = (state_reg == S_KVOL);
    assign cmd.restart = (state_reg == S_RESTART);
    assign cmd.emit = (state_reg == S_EMIT) && sts.out_free;
    assign cmd.list_emit = (state_reg == S_LIST) && sts.out_free;

endmodule

>>> hw/rtl/mpcc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcc_dp: panel datapath
// Holds the channel state, knob history, volumes, standby countdown, hue and
// led latch, and the result register; acts on sequencer commands.
// ----------------------------------------------------------------------------
module mpcc_dp #(
    parameter int CHANNELS = mpcc_pkg::CHANNELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mpcc_pkg::in_t  item,
    output mpcc_pkg::out_t result,
    output logic           result_valid,
    input  logic           result_ready,
    input  mpcc_pkg::cfg_t cfg,
    input  mpcc_pkg::cmd_t cmd,
    output mpcc_pkg::sts_t sts
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LC = mpcc_pkg::LED_CHANNELS;
    localparam logic [CW-1:0] LAST_IDX = CW'(CHANNELS - 1);

    mpcc_pkg::in_t  item_reg, item_next;
    mpcc_pkg::out_t result_reg, result_next;
    logic result_valid_reg, result_valid_next;
    logic [CHANNELS-1:0] pressed_reg, pressed_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [CHANNELS-1:0] mute_reg, mute_next;
    logic [7:0] last_raw_reg [CHANNELS];
    logic [7:0] last_raw_next [CHANNELS];
    logic [6:0] volume_reg [CHANNELS];
    logic [6:0] volume_next [CHANNELS];
    logic [15:0] standby_left_reg, standby_left_next;
    logic [7:0] hue_reg, hue_next;
    logic [11:0] led_reg, led_next;
    logic host_seen_reg, host_seen_next;
    logic [14:0] prod_reg, prod_next;
    logic [6:0] vol_reg, vol_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [CW-1:0] idx;
    logic [CW-1:0] rd_addr;
    logic [7:0] raw;
    logic [7:0] last_rd;
    logic [6:0] vol_rd;
    logic [7:0] diff;
    logic [15:0] quot_sum;
    logic [6:0] vol_calc;
    logic [LC-1:0] act_led, mute_led, press_led;
    logic [11:0] codes;
    logic out_free;
    logic in_standby;

    // decode of the held beat
    assign idx = CW'(item_reg.chan);
    assign rd_addr = cmd.list_emit ? cnt_reg : idx;
    assign raw = item_reg.sample[9:2];
    assign last_rd = last_raw_reg[idx];
    assign vol_rd = volume_reg[rd_addr];
    assign diff = (raw > last_rd) ? (raw - last_rd) : (last_rd - raw);
    assign in_standby = (standby_left_reg == 16'd0);
    assign out_free = !result_valid_reg || result_ready;

    // divide by 255 as (x + (x >> 8) + 1) >> 8
    assign quot_sum = 16'(prod_reg) + 16'(prod_reg[14:8]) + 16'd1;
    assign vol_calc = quot_sum[14:8];

    // led codes from the channel bits
    assign act_led = LC'(active_reg);
    assign mute_led = LC'(mute_reg);
    assign press_led = LC'(pressed_reg);
    always_comb
    begin
        codes = '0;
        for (int i = 0; i < LC; i++)
        begin
            if (!act_led[i])
                codes[2*i +: 2] = press_led[i] ? mpcc_pkg::LED_BLUE : mpcc_pkg::LED_OFF;
            else if (mute_led[i])
                codes[2*i +: 2] = mpcc_pkg::LED_RED;
            else
                codes[2*i +: 2] = mpcc_pkg::LED_GREEN;
        end
    end

    // status
    assign sts.opcode = item_reg.opcode;
    assign sts.chan_ok = (32'(item_reg.chan) < 32'(CHANNELS));
    assign sts.knob_move = (diff > cfg.knob_deadband);
    assign sts.press = item_reg.level && !pressed_reg[idx];
    assign sts.release_evt = !item_reg.level && pressed_reg[idx];
    assign sts.active_hit = active_reg[idx];
    assign sts.vol_change = (vol_calc != vol_rd);
    assign sts.host_seen = host_seen_reg;
    assign sts.list_last = (cnt_reg == LAST_IDX);
    assign sts.out_free = out_free;

    // state update
    always_comb
    begin
        item_next = item_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        pressed_next = pressed_reg;
        active_next = active_reg;
        mute_next = mute_reg;
        last_raw_next = last_raw_reg;
        volume_next = volume_reg;
        standby_left_next = standby_left_reg;
        hue_next = hue_reg;
        led_next = led_reg;
        host_seen_next = host_seen_reg;
        prod_next = prod_reg;
        vol_next = vol_reg;
        cnt_next = cnt_reg;

        if (cmd.load_in)
        begin
            item_next = item;
        end

        // first phase of each opcode
        if (cmd.exec)
        begin
            case (item_reg.opcode)
                mpcc_pkg::OP_TICK:
                begin
                    if (16'(item_reg.elapsed_ms) >= standby_left_reg)
                        standby_left_next = '0;
                    else
                        standby_left_next = standby_left_reg - 16'(item_reg.elapsed_ms);
                end
                mpcc_pkg::OP_KNOB:
                begin
                    if (sts.chan_ok && sts.knob_move)
                    begin
                        last_raw_next[idx] = raw;
                        prod_next = 15'(raw * mpcc_pkg::VOL_SCALE) + 15'(mpcc_pkg::VOL_ROUND);
                    end
                end
                mpcc_pkg::OP_BUTTON:
                begin
                    if (sts.chan_ok && sts.press)
                    begin
                        pressed_next[idx] = 1'b1;
                        if (active_reg[idx])
                            mute_next[idx] = !mute_reg[idx];
                    end
                    else if (sts.chan_ok && sts.release_evt)
                    begin
                        pressed_next[idx] = 1'b0;
                    end
                end
                mpcc_pkg::OP_ACTIVE:
                begin
                    host_seen_next = 1'b1;
                    active_next = CHANNELS'(item_reg.mask);
                end
                mpcc_pkg::OP_MUTE:
                begin
                    host_seen_next = 1'b1;
                    mute_next = CHANNELS'(item_reg.mask);
                end
                mpcc_pkg::OP_VOL_REQ:
                begin
                    host_seen_next = 1'b1;
                    cnt_next = '0;
                end
                mpcc_pkg::OP_HOST:
                begin
                    host_seen_next = 1'b1;
                end
                default:
                begin
                    host_seen_next = host_seen_reg;
                end
            endcase
        end

        // scaled volume
        if (cmd.knob_vol)
        begin
            vol_next = vol_calc;
            if (sts.vol_change)
                volume_next[idx] = vol_calc;
        end

        // standby reload and led latch
        if (cmd.restart)
        begin
            standby_left_next = cfg.standby_delay_ms;
            led_next = codes;
        end

        // single report beat
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
            result_next.last = 1'b0;
            result_next.standby = in_standby;
            result_next.hue = hue_reg;
            result_next.led_codes = led_reg;
            case (item_reg.opcode)
                mpcc_pkg::OP_TICK:
                begin
                    result_next.kind = mpcc_pkg::KIND_STATUS;
                    result_next.chan_out = '0;
                    result_next.value = '0;
                    if (in_standby)
                        hue_next = hue_reg - 8'd1;
                end
                mpcc_pkg::OP_KNOB:
                begin
                    result_next.kind = mpcc_pkg::KIND_VOLUME;
                    result_next.chan_out = item_reg.chan;
                    result_next.value = vol_reg;
                end
                default:
                begin
                    result_next.kind = mpcc_pkg::KIND_MUTE;
                    result_next.chan_out = item_reg.chan;
                    result_next.value = 7'(mute_reg[idx]);
                end
            endcase
        end

        // volume list entry
        if (cmd.list_emit)
        begin
            result_valid_next = 1'b1;
            result_next.kind = mpcc_pkg::KIND_LIST;
            result_next.chan_out = 3'(cnt_reg);
            result_next.value = vol_rd;
            result_next.last = (cnt_reg == LAST_IDX);
            result_next.standby = in_standby;
            result_next.hue = hue_reg;
            result_next.led_codes = led_reg;
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        result_reg <= result_next;
        prod_reg <= prod_next;
        vol_reg <= vol_next;
    end

    // panel state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            pressed_reg <= '0;
            active_reg <= '0;
            mute_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_raw_reg[i] <= '0;
                volume_reg[i] <= '0;
            end
            standby_left_reg <= '0;
            hue_reg <= '0;
            led_reg <= '0;
            host_seen_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            pressed_reg <= pressed_next;
            active_reg <= active_next;
            mute_reg <= mute_next;
            last_raw_reg <= last_raw_next;
            volume_reg <= volume_next;
            standby_left_reg <= standby_left_next;
            hue_reg <= hue_next;
            led_reg <= led_next;
            host_seen_reg <= host_seen_next;
            cnt_reg <= cnt_next;
        end
    end

    assign result = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> hw/rtl/mixer_panel_channel_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixer_panel_channel_controller_top: volume front panel controller
// Turns knob, button, tick and host command beats into display status,
// volume, mute and volume list reports, with standby rainbow timing.
// ----------------------------------------------------------------------------
// The panel takes one input beat at a time through a small sequencer with
// execute, volume scaling, standby reload and report phases: a tick runs
// execute and report, a reporting knob sample all four, a reporting button
// press all but volume scaling, a volume request execute, then one list entry
// per cycle while the result side is free. A mask command, a button release
// or a press on an inactive channel runs execute and standby reload, a knob
// move with no report stops after volume scaling; beats that change nothing run
// execute alone. The single result register holds each report until taken.
// Configuration registers at byte addresses 0 (standby delay, ms) and 4
// (knob deadband) must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module mixer_panel_channel_controller_top #(
    parameter int CHANNELS = mpcc_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  mpcc_pkg::in_t                item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output mpcc_pkg::out_t               result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpcc_pkg::PADDR_W-1:0] paddr,
    input  logic [mpcc_pkg::PDATA_W-1:0] pwdata,
    output logic [mpcc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    mpcc_pkg::cfg_t cfg;
    mpcc_pkg::cmd_t cmd;
    mpcc_pkg::sts_t sts;

    // configuration registers
    mpcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    mpcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    mpcc_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

>>> sim/mpcc_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpcc_report_checker: prediction and comparison for the panel controller
// Watches the input, result and register channels. Each accepted input beat
// runs through a copy of the panel state to build the reports it should
// cause. Each accepted result beat is compared field by field against the
// oldest pending report.
// ----------------------------------------------------------------------------
module mpcc_report_checker #(
    parameter int CHANNELS = mpcc_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  mpcc_pkg::in_t                item,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  mpcc_pkg::out_t               result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpcc_pkg::PADDR_W-1:0] paddr,
    input  logic [mpcc_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           errors,
    output int                           outstanding,
    output int                           reports_seen
);
    import mpcc_pkg::*;

    // register copies
    logic [15:0] delay_ms;
    logic [7:0]  deadband;

    // panel state copy
    logic [5:0]  pressed;
    logic [5:0]  active;
    logic [5:0]  muted;
    logic [7:0]  knob_raw [CHANNELS];
    logic [6:0]  vol [CHANNELS];
    logic [15:0] standby_left;
    logic [7:0]  hue;
    logic [11:0] leds;
    logic        host_seen;

    // reports still to come, oldest first
    out_t pending_reports [$];

    // countdown reload and led code rebuild on button edges, masks, knob reports
    task automatic reload_standby();
        logic [11:0] codes;
        logic [1:0]  c;
        int          i;
        codes = '0;
        standby_left = delay_ms;
        for (i = 0; i < CHANNELS && i < LED_CHANNELS; i++) begin
            if (!active[i])
                c = pressed[i] ? LED_BLUE : LED_OFF;
            else if (muted[i])
                c = LED_RED;
            else
                c = LED_GREEN;
            codes[2*i +: 2] = c;
        end
        leds = codes;
    endtask

    task automatic push_report(input logic [1:0] kind, input logic [2:0] ch,
                               input logic [6:0] val, input logic lst,
                               input logic sb, input logic [7:0] hv);
        out_t r;
        r.kind      = kind;
        r.chan_out  = ch;
        r.value     = val;
        r.last      = lst;
        r.standby   = sb;
        r.hue       = hv;
        r.led_codes = leds;
        pending_reports.push_back(r);
    endtask

    // advance the panel state by one input beat
    task automatic predict_panel(input in_t it);
        logic [7:0]  raw;
        logic [7:0]  diff;
        logic [5:0]  sel;
        logic        hit;
        int unsigned scaled;
        int          i;
        case (it.opcode)
            OP_TICK:
            begin
                if (it.elapsed_ms >= standby_left)
                    standby_left = '0;
                else
                    standby_left = standby_left - it.elapsed_ms;
                // standby shows the current hue, then steps it down
                if (standby_left == 0)
                begin
                    push_report(KIND_STATUS, 3'd0, 7'd0, 1'b0, 1'b1, hue);
                    hue = hue - 8'd1;
                end
                else
                begin
                    push_report(KIND_STATUS, 3'd0, 7'd0, 1'b0, 1'b0, hue);
                end
            end
            OP_KNOB:
            begin
                if (it.chan < CHANNELS)
                begin
                    raw  = it.sample[9:2];
                    diff = (raw > knob_raw[it.chan]) ? raw - knob_raw[it.chan]
                                                     : knob_raw[it.chan] - raw;
                    if (diff > deadband)
                    begin
                        knob_raw[it.chan] = raw;
                        // rounded raw * 100 / 255
                        scaled = (32'(raw) * 100 + 127) / 255;
                        if (scaled[6:0] != vol[it.chan])
                        begin
                            vol[it.chan] = scaled[6:0];
                            if (host_seen)
                            begin
                                reload_standby();
                                push_report(KIND_VOLUME, it.chan, scaled[6:0], 1'b0,
                                            standby_left == 0, hue);
                            end
                        end
                    end
                end
            end
            OP_BUTTON:
            begin
                if (it.chan < CHANNELS)
                begin
                    sel = 6'b1 << it.chan;
                    if (it.level && !(|(pressed & sel)))
                    begin
                        // press: toggles mute only on an active channel
                        hit = |(active & sel);
                        pressed = pressed | sel;
                        if (hit)
                            muted = muted ^ sel;
                        reload_standby();
                        if (hit)
                            push_report(KIND_MUTE, it.chan, {6'd0, |(muted & sel)}, 1'b0,
                                        standby_left == 0, hue);
                    end
                    else if (!it.level && |(pressed & sel))
                    begin
                        pressed = pressed & ~sel;
                        reload_standby();
                    end
                end
            end
            OP_ACTIVE:
            begin
                host_seen = 1'b1;
                active = it.mask;
                reload_standby();
            end
            OP_MUTE:
            begin
                host_seen = 1'b1;
                muted = it.mask;
                reload_standby();
            end
            OP_VOL_REQ:
            begin
                host_seen = 1'b1;
                for (i = 0; i < CHANNELS; i++)
                    push_report(KIND_LIST, 3'(i), vol[i], i == CHANNELS - 1,
                                standby_left == 0, hue);
            end
            OP_HOST:
            begin
                host_seen = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        int   i;
        if (!rst_n)
        begin
            delay_ms     = STANDBY_DELAY_RST;
            deadband     = KNOB_DEADBAND_RST;
            pressed      = '0;
            active       = '0;
            muted        = '0;
            for (i = 0; i < CHANNELS; i++)
            begin
                knob_raw[i] = '0;
                vol[i]      = '0;
            end
            standby_left = '0;
            hue          = '0;
            leds         = '0;
            host_seen    = 1'b0;
            pending_reports.delete();
            errors       = 0;
            outstanding  = 0;
            reports_seen = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_STANDBY_DELAY, 2'b00})
                    delay_ms = pwdata[15:0];
                else if (paddr == {REG_KNOB_DEADBAND, 2'b00})
                    deadband = pwdata[7:0];
            end

            // result beats against the oldest pending report
            if (result_valid && result_ready)
            begin
                reports_seen++;
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    $error("report with none pending: kind %0d chan_out %0d value %0d",
                           result.kind, result.chan_out, result.value);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("kind", want.kind, result.kind);
                    check_field("chan_out", want.chan_out, result.chan_out);
                    check_field("value", want.value, result.value);
                    check_field("last", want.last, result.last);
                    check_field("standby", want.standby, result.standby);
                    check_field("hue", want.hue, result.hue);
                    check_field("led_codes", want.led_codes, result.led_codes);
                end
            end

            // input beats
            if (item_valid && item_ready)
                predict_panel(item);

            outstanding = pending_reports.size();
        end
    end

endmodule

>>> sim/tb_mixer_panel_channel_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixer_panel_channel_controller_top: panel controller testbench
// Drives directed and random knob, button, tick and host beats through the
// controller under several standby delay and deadband settings, with random
// gaps on the input side and random stalls on the result side. A checker
// beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_mixer_panel_channel_controller_top;
    import mpcc_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BEATS   = 30;
    localparam int NUM_SETTINGS  = 6;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    in_t                 item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_t                result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int errors;
    int outstanding;
    int reports_seen;

    // stimulus bookkeeping
    bit         calm = 1'b0;
    int         beats_sent = 0;
    logic [9:0] knob_pos [CHANNELS];
    bit         button_pos [CHANNELS];

    mixer_panel_channel_controller_top #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    mpcc_report_checker #(
        .CHANNELS(CHANNELS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .errors(errors),
        .outstanding(outstanding),
        .reports_seen(reports_seen)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("** mixer_panel_channel_controller_top: FAILED **");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // result side stalls
    always
    begin
        @(negedge clk);
        if (calm || $urandom_range(0, 99) < 70)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= 1'b0;
            repeat (idle_len()) @(negedge clk);
        end
    end

    function automatic in_t panel_beat(input logic [2:0] op, input logic [2:0] ch,
                                       input logic [9:0] smp, input logic lvl,
                                       input logic [5:0] msk, input logic [7:0] ms);
        in_t b;
        b.opcode     = op;
        b.chan       = ch;
        b.sample     = smp;
        b.level      = lvl;
        b.mask       = msk;
        b.elapsed_ms = ms;
        return b;
    endfunction

    // present one beat, called at a falling edge, returns at a falling edge
    task automatic send_beat(input in_t b);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 50) ? 0 : idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // register write with setup and access phases, called at a falling edge
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, drain every pending report, let the sequencer settle
    task automatic drain_panel();
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random beat, weighted toward well-formed panel activity
    task automatic make_panel_event(output in_t b, output bit counts);
        logic [31:0] r;
        int          pick;
        int          ch;
        int          s;
        r = $urandom;
        b = r[30:0];
        pick = $urandom_range(0, 99);
        ch = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        counts = 1'b1;
        if (pick < 26)
        begin
            b.opcode = OP_TICK;
            case ($urandom_range(0, 5))
                0: b.elapsed_ms = 8'd0;
                1: b.elapsed_ms = 8'd255;
                2, 3: b.elapsed_ms = 8'($urandom_range(0, 15));
                default: b.elapsed_ms = 8'($urandom);
            endcase
        end
        else if (pick < 52)
        begin
            b.opcode = OP_KNOB;
            b.chan   = 3'(ch);
            if (ch < CHANNELS)
            begin
                // small moves around the deadband, otherwise a fresh position
                if ($urandom_range(0, 9) < 4)
                begin
                    s = int'(knob_pos[ch]) + int'($urandom_range(0, 40)) - 20;
                    if (s < 0)
                        s = 0;
                    if (s > 1023)
                        s = 1023;
                    b.sample = 10'(s);
                end
                knob_pos[ch] = b.sample;
            end
            else
            begin
                counts = 1'b0;
            end
        end
        else if (pick < 72)
        begin
            b.opcode = OP_BUTTON;
            b.chan   = 3'(ch);
            if (ch < CHANNELS)
            begin
                b.level = ($urandom_range(0, 3) != 0) ? !button_pos[ch] : 1'($urandom);
                button_pos[ch] = b.level;
            end
            else
            begin
                counts = 1'b0;
            end
        end
        else if (pick < 79)
        begin
            b.opcode = OP_ACTIVE;
        end
        else if (pick < 86)
        begin
            b.opcode = OP_MUTE;
        end
        else if (pick < 91)
        begin
            b.opcode = OP_VOL_REQ;
        end
        else if (pick < 96)
        begin
            b.opcode = OP_HOST;
        end
        else
        begin
            b.opcode = 3'd7;
            counts = 1'b0;
        end
    endtask

    // stimulus
    initial
    begin
        logic [15:0] delay_set [NUM_SETTINGS];
        logic [7:0]  band_set [NUM_SETTINGS];
        in_t         b;
        bit          counts;
        int          useful;
        int          p;
        int          i;

        delay_set = '{16'd50, 16'd0, 16'd65535, 16'd300, 16'd1, 16'($urandom)};
        band_set  = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd8, 8'($urandom)};
        for (i = 0; i < CHANNELS; i++)
        begin
            knob_pos[i]   = '0;
            button_pos[i] = 1'b0;
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings
        send_beat(panel_beat(OP_TICK, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd0, 10'd1023, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd0, 10'd0, 1'b1, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd0, 10'd0, 1'b1, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd6, 10'd1023, 1'b1, 6'd63, 8'd255));
        send_beat(panel_beat(OP_BUTTON, 3'd7, 10'd1023, 1'b1, 6'd63, 8'd255));
        send_beat(panel_beat(3'd7, 3'd0, 10'd0, 1'b1, 6'd63, 8'd255));
        send_beat(panel_beat(OP_HOST, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_VOL_REQ, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_ACTIVE, 3'd0, 10'd0, 1'b0, 6'd63, 8'd0));
        send_beat(panel_beat(OP_MUTE, 3'd0, 10'd0, 1'b0, 6'd42, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd1, 10'd1023, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd1, 10'd1020, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd1, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd2, 10'd4, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_KNOB, 3'd2, 10'd8, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd3, 10'd0, 1'b1, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd3, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_BUTTON, 3'd5, 10'd0, 1'b1, 6'd0, 8'd0));
        send_beat(panel_beat(OP_TICK, 3'd0, 10'd0, 1'b0, 6'd0, 8'd255));
        send_beat(panel_beat(OP_ACTIVE, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_MUTE, 3'd0, 10'd0, 1'b0, 6'd63, 8'd0));
        send_beat(panel_beat(OP_VOL_REQ, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        send_beat(panel_beat(OP_TICK, 3'd0, 10'd0, 1'b0, 6'd0, 8'd0));
        button_pos[5] = 1'b1;

        // random part, one register setting per phase
        for (p = 0; p < NUM_SETTINGS; p++)
        begin
            drain_panel();
            reg_write({REG_STANDBY_DELAY, 2'b00}, 32'(delay_set[p]));
            @(negedge clk);
            reg_write({REG_KNOB_DEADBAND, 2'b00}, 32'(band_set[p]));
            @(negedge clk);
            useful = 0;
            while (useful < PHASE_BEATS)
            begin
                // stretches with no idling on either side
                if (useful % 12 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                make_panel_event(b, counts);
                send_beat(b);
                if (counts)
                    useful++;
            end
        end
        calm = 1'b0;

        drain_panel();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d input beats, %0d register settings, %0d reports checked",
                 beats_sent, NUM_SETTINGS + 1, reports_seen);
        if (errors == 0 && outstanding == 0)
            $display("** mixer_panel_channel_controller_top: PASSED **");
        else
            $display("** mixer_panel_channel_controller_top: FAILED **");
        $finish;
    end

endmodule
